[design/crash_rate_exec_guard_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros for the crash-rate exec guard
// ---------------------------------------------------------------------------
`ifndef CRASH_RATE_EXEC_GUARD_MACROS_SVH
`define CRASH_RATE_EXEC_GUARD_MACROS_SVH
`ifndef SYNTHESIS
`define CREG_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define CREG_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CREG_ASSERT(label, clk, rst, prop)
`define CREG_ASSERT_NR(label, clk, prop)
`endif
`endif

[design/creg_pkg.sv]
// ---------------------------------------------------------------------------
// creg_pkg
// constants, types and hash function for the crash-rate exec guard
// ---------------------------------------------------------------------------
package creg_pkg;
  localparam int TABLE_ENTRIES = 512;
  localparam int WAYS = 4;
  localparam int NOGUARD_BIT = 3;
  localparam int SET_COUNT = TABLE_ENTRIES / WAYS;
  localparam int SET_W = $clog2(SET_COUNT);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [31:0] ODD_BITS = 32'haaaaaaaa;
  localparam logic [31:0] EVEN_BITS = 32'h55555555;
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] CFG_GUARD_MODE = 2'd0;
  localparam logic [1:0] CFG_EXPIRY = 2'd1;
  localparam logic [1:0] CFG_SUSPEND = 2'd2;
  localparam logic [1:0] CFG_MAX_CRASHES = 2'd3;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_OPT_IN = 2'd1;
  localparam logic [1:0] MODE_OPT_OUT = 2'd2;
  localparam logic [1:0] MODE_ALWAYS = 2'd3;

  typedef enum logic [2:0] {
    EV_UNGUARDED = 3'd0, EV_PASSED = 3'd1, EV_DENIED = 3'd2, EV_ADDED = 3'd3,
    EV_COUNTED = 3'd4, EV_RESET = 3'd5, EV_SUSPENDED = 3'd6, EV_FULL = 3'd7
  } event_t;

  typedef enum logic [1:0] {ST_IDLE, ST_HASH, ST_LOOK, ST_OUT} state_t;

  typedef struct packed {
    logic [7:0]  count;
    logic [31:0] expiry;
    logic [31:0] susp;
    logic [31:0] user;
    logic [63:0] file;
    logic [15:0] mount;
  } entry_t;

  // one set: valid bits and all ways side by side
  typedef struct packed {
    logic [WAYS-1:0]   valid;
    entry_t [WAYS-1:0] way;
  } set_word_t;

  // one fnv-1a byte step
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hffffffff : s[31:0];
  endfunction
endpackage

[design/crash_rate_exec_guard.sv]
// ---------------------------------------------------------------------------
// crash_rate_exec_guard
// crash-rate table with exec suspension, set-associative memory
// ---------------------------------------------------------------------------
// an unguarded item leaves the hash state with a zero result; a guarded item
// runs through the byte-serial fnv hash of its 14 key bytes (one multiplier
// step a cycle), then one set read and, for a crash report, one write-back
// reset clears control state, then a pass over all 128 sets clears the table before the first item
// next item is taken once the previous result has left the output register
`include "crash_rate_exec_guard_macros.svh"
module crash_rate_exec_guard (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [175:0] s_tdata,  // user_id, file_id, mount_id, now_seconds, guard_flags
  input  logic [1:0]   s_tuser,  // crashed, setid_file
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,  // denied, event_res
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  localparam int SW = creg_pkg::SET_W;
  localparam int WW = creg_pkg::WAY_W;
  localparam int NW = creg_pkg::WAYS;

  creg_pkg::state_t state, state_next;
  logic [1:0]  guard_mode;
  logic [15:0] expiry_seconds, suspend_seconds;
  logic [7:0]  crash_limit;

  logic        crashed, setid;
  logic [31:0] user, now, flags;
  logic [63:0] file;
  logic [15:0] mount;
  logic [111:0] key;
  logic [31:0] hash, hash_next;
  logic [3:0]  bcnt;
  logic [SW-1:0] set, set_next;

  logic          clearing;
  logic [SW-1:0] clr_set;

  creg_pkg::set_word_t mem [creg_pkg::SET_COUNT];
  creg_pkg::set_word_t rd, wr_word;

  logic [2:0] ev;
  logic       guarded;

  logic [NW-1:0] hitv, freev;
  logic [WW-1:0] hit_w, free_w, tgt_w;
  logic hit, freef;
  creg_pkg::entry_t he, wr;
  logic [8:0] cinc;

  assign s_tready = (state == creg_pkg::ST_IDLE) && !m_tvalid && !clearing;

  always_comb begin
    logic [31:0] odd;
    odd = flags & creg_pkg::ODD_BITS;
    guarded = 1'b0;
    if ((odd & ((flags & creg_pkg::EVEN_BITS) << 1)) != 32'd0) guarded = 1'b1;
    else begin
      unique case (guard_mode)
        creg_pkg::MODE_OFF:     guarded = 1'b0;
        creg_pkg::MODE_OPT_IN:  guarded = setid;
        creg_pkg::MODE_OPT_OUT: guarded = !flags[creg_pkg::NOGUARD_BIT];
        default:                guarded = 1'b1;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      creg_pkg::ST_IDLE: if (s_tvalid && s_tready) state_next = creg_pkg::ST_HASH;
      creg_pkg::ST_HASH: begin
        if (!guarded) state_next = creg_pkg::ST_OUT;
        else if (bcnt == 4'd13) state_next = creg_pkg::ST_LOOK;
      end
      creg_pkg::ST_LOOK: state_next = creg_pkg::ST_OUT;
      default: state_next = creg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= creg_pkg::ST_IDLE;
      guard_mode <= 2'd1;
      expiry_seconds <= 16'd120;
      suspend_seconds <= 16'd600;
      crash_limit <= 8'd5;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          creg_pkg::CFG_GUARD_MODE:  guard_mode <= cfg_data[1:0];
          creg_pkg::CFG_EXPIRY:      expiry_seconds <= cfg_data;
          creg_pkg::CFG_SUSPEND:     suspend_seconds <= cfg_data;
          default:                   crash_limit <= cfg_data[7:0];
        endcase
      end
    end
  end

  // table clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_set <= '0;
    end else if (clearing) begin
      clr_set <= clr_set + SW'(1);
      if (clr_set == SW'(creg_pkg::SET_COUNT - 1)) clearing <= 1'b0;
    end
  end

  assign hash_next = creg_pkg::fnv_step(hash, key[7:0]);
  assign set_next = hash_next[SW-1:0];
  assign set = hash[SW-1:0];

  // input capture and byte-serial hash
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      crashed <= s_tuser[0];
      setid <= s_tuser[1];
      user <= s_tdata[31:0];
      file <= s_tdata[95:32];
      mount <= s_tdata[111:96];
      now <= s_tdata[143:112];
      flags <= s_tdata[175:144];
      key <= s_tdata[111:0];
      hash <= creg_pkg::FNV_BASIS;
      bcnt <= 4'd0;
    end else if (state == creg_pkg::ST_HASH) begin
      hash <= hash_next;
      key <= key >> 8;
      bcnt <= bcnt + 4'd1;
    end
  end

  // set read, registered; the last hash step gives the address
  always_ff @(posedge clk) begin
    if (state == creg_pkg::ST_HASH) rd <= mem[set_next];
  end

  always_comb begin
    hitv = '0; freev = '0; hit = 1'b0; freef = 1'b0; hit_w = '0; free_w = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      freev[w] = !rd.valid[w];
      hitv[w] = rd.valid[w] && rd.way[w].user == user && rd.way[w].file == file
                && rd.way[w].mount == mount;
      if (freev[w]) begin free_w = WW'(w); freef = 1'b1; end
      if (hitv[w]) begin hit_w = WW'(w); hit = 1'b1; end
    end
    he = rd.way[hit_w];
    cinc = {1'b0, he.count} + 9'd1;
    wr = he;
    tgt_w = hit ? hit_w : free_w;
    if (!crashed) begin
      ev = (hit && he.susp > now) ? creg_pkg::EV_DENIED : creg_pkg::EV_PASSED;
    end else if (!hit) begin
      ev = freef ? creg_pkg::EV_ADDED : creg_pkg::EV_FULL;
      wr = '{count: 8'd1, expiry: creg_pkg::sat_add(now, expiry_seconds), susp: 32'd0,
             user: user, file: file, mount: mount};
    end else if (he.expiry < now && he.susp <= now) begin
      ev = creg_pkg::EV_RESET;
      wr.count = 8'd1;
      wr.expiry = creg_pkg::sat_add(now, expiry_seconds);
      wr.susp = 32'd0;
    end else if (cinc >= {1'b0, crash_limit}) begin
      ev = creg_pkg::EV_SUSPENDED;
      wr.susp = creg_pkg::sat_add(now, suspend_seconds);
      wr.count = 8'd0;
      wr.expiry = 32'd0;
    end else begin
      ev = creg_pkg::EV_COUNTED;
      wr.count = cinc[7:0];
    end
    wr_word = rd;
    wr_word.valid[tgt_w] = 1'b1;
    wr_word.way[tgt_w] = wr;
  end

  always_ff @(posedge clk) begin
    if (clearing) mem[clr_set] <= '0;
    else if (state == creg_pkg::ST_LOOK && crashed && ev != creg_pkg::EV_FULL)
      mem[set] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
    else if (state == creg_pkg::ST_OUT) m_tvalid <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == creg_pkg::ST_LOOK) m_tdata <= {4'd0, ev, ev == creg_pkg::EV_DENIED};
    else if (state == creg_pkg::ST_HASH && !guarded) m_tdata <= 8'd0;
  end

  `CREG_ASSERT(a_no_accept_busy, clk, rst, (state != creg_pkg::ST_IDLE) |-> !s_tready)
  `CREG_ASSERT(a_no_accept_clear, clk, rst, clearing |-> !s_tready)
  `CREG_ASSERT(a_out_after, clk, rst, (state == creg_pkg::ST_OUT) |=> m_tvalid)
  `CREG_ASSERT(a_denied_ev, clk, rst, m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == creg_pkg::EV_DENIED)))
endmodule

[dv/crash_rate_exec_guard_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// crash_rate_exec_guard_tb
// drives exec checks and crash reports through the guard, predicts each
// result from a local copy of the crash table and compares it field by field
// ---------------------------------------------------------------------------
module crash_rate_exec_guard_tb;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [31:0] user;
    logic [63:0] file;
    logic [15:0] mount;
  } key_t;

  typedef struct packed {
    logic             denied;
    creg_pkg::event_t ev;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [175:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  crash_rate_exec_guard dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata),  // user_id, file_id, mount_id, now_seconds, guard_flags
    .s_tuser(s_tuser),  // crashed, setid_file
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata),  // denied, event_res
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // local copy of guard settings and crash table
  logic [1:0]  mode_q = creg_pkg::MODE_OPT_IN;
  logic [15:0] expiry_q = 16'd120;
  logic [15:0] suspend_q = 16'd600;
  logic [7:0]  limit_q = 8'd5;
  logic        tbl_valid [creg_pkg::TABLE_ENTRIES];
  key_t        tbl_key [creg_pkg::TABLE_ENTRIES];
  logic [7:0]  tbl_count [creg_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_expiry [creg_pkg::TABLE_ENTRIES];
  logic [31:0] tbl_susp [creg_pkg::TABLE_ENTRIES];

  verdict_t verdict_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  logic [31:0] clock_now = 32'd1000;
  key_t key_pool[$];

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int unsigned set_of(input key_t k);
    logic [111:0] bytes;
    logic [31:0] h;
    bytes = {k.mount, k.file, k.user};
    h = 32'h811c9dc5;
    for (int i = 0; i < 14; i++) h = (h ^ {24'd0, bytes[8*i +: 8]}) * 32'd16777619;
    return h % creg_pkg::SET_COUNT;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hffffffff : s[31:0];
  endfunction

  function automatic verdict_t guard_verdict(input logic crashed, input key_t k,
      input logic [31:0] now, input logic setid, input logic [31:0] flags);
    verdict_t v;
    bit guarded;
    int base, hit, freeway;
    logic [8:0] c;
    hit = -1;
    freeway = -1;
    v.ev = creg_pkg::EV_UNGUARDED;
    if (((flags & creg_pkg::ODD_BITS) & ((flags & creg_pkg::EVEN_BITS) << 1)) != 0)
      guarded = 1;
    else case (mode_q)
      creg_pkg::MODE_OFF: guarded = 0;
      creg_pkg::MODE_OPT_IN: guarded = setid;
      creg_pkg::MODE_OPT_OUT: guarded = !flags[creg_pkg::NOGUARD_BIT];
      default: guarded = 1;
    endcase
    if (guarded) begin
      base = set_of(k) * creg_pkg::WAYS;
      for (int w = 0; w < creg_pkg::WAYS; w++) begin
        if (!tbl_valid[base+w]) begin
          if (freeway < 0) freeway = base + w;
        end else if (hit < 0 && tbl_key[base+w] == k) begin
          hit = base + w;
        end
      end
      if (!crashed) begin
        v.ev = (hit >= 0 && tbl_susp[hit] > now) ? creg_pkg::EV_DENIED : creg_pkg::EV_PASSED;
      end else if (hit < 0) begin
        if (freeway < 0) v.ev = creg_pkg::EV_FULL;
        else begin
          tbl_valid[freeway] = 1;
          tbl_key[freeway] = k;
          tbl_count[freeway] = 8'd1;
          tbl_expiry[freeway] = add_sat(now, expiry_q);
          tbl_susp[freeway] = '0;
          v.ev = creg_pkg::EV_ADDED;
        end
      end else if (tbl_expiry[hit] < now && tbl_susp[hit] <= now) begin
        tbl_count[hit] = 8'd1;
        tbl_expiry[hit] = add_sat(now, expiry_q);
        tbl_susp[hit] = '0;
        v.ev = creg_pkg::EV_RESET;
      end else begin
        c = {1'b0, tbl_count[hit]} + 9'd1;
        if (c >= {1'b0, limit_q}) begin
          tbl_susp[hit] = add_sat(now, suspend_q);
          tbl_count[hit] = '0;
          tbl_expiry[hit] = '0;
          v.ev = creg_pkg::EV_SUSPENDED;
        end else begin
          tbl_count[hit] = c[7:0];
          v.ev = creg_pkg::EV_COUNTED;
        end
      end
    end
    v.denied = (v.ev == creg_pkg::EV_DENIED);
    return v;
  endfunction

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input logic crashed, input key_t k, input logic [31:0] now,
      input logic setid, input logic [31:0] flags);
    int g;
    s_tvalid <= 1'b1;
    s_tdata <= {flags, now, k.mount, k.file, k.user};
    s_tuser <= {setid, crashed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    verdict_q.push_back(guard_verdict(crashed, k, now, setid, flags));
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      creg_pkg::CFG_GUARD_MODE: mode_q = val[1:0];
      creg_pkg::CFG_EXPIRY: expiry_q = val;
      creg_pkg::CFG_SUSPEND: suspend_q = val;
      default: limit_q = val[7:0];
    endcase
  endtask

  task automatic set_all(input logic [1:0] m, input logic [15:0] e, input logic [15:0] s,
      input logic [7:0] l);
    write_reg(creg_pkg::CFG_GUARD_MODE, {14'd0, m});
    write_reg(creg_pkg::CFG_EXPIRY, e);
    write_reg(creg_pkg::CFG_SUSPEND, s);
    write_reg(creg_pkg::CFG_MAX_CRASHES, {8'd0, l});
  endtask

  function automatic key_t rand_key();
    key_t k;
    k.user = $urandom;
    k.file = {$urandom, $urandom};
    k.mount = 16'($urandom);
    return k;
  endfunction

  function automatic key_t key_in_set(input int unsigned s);
    key_t k;
    do k = rand_key(); while (set_of(k) != s);
    return k;
  endfunction

  // sink side stall pattern
  initial begin
    @(negedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (!quiet) begin
        m_tready <= 1'b0;
        repeat (gap_len() + 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) report("result with nothing expected");
      else begin
        exp_v = verdict_q.pop_front();
        if (m_tdata[0] !== exp_v.denied)
          report($sformatf("denied %b expected %b", m_tdata[0], exp_v.denied));
        if (m_tdata[3:1] !== exp_v.ev)
          report($sformatf("event_res %0d expected %0d", m_tdata[3:1], exp_v.ev));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("crash_rate_exec_guard test failed");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    key_t k;
    k = rand_key();
    send_item(1'b0, k, clock_now, 1'b0, 32'h0);
    send_item(1'b0, k, clock_now, 1'b1, 32'h0);
    repeat (5) begin
      send_item(1'b1, k, clock_now, 1'b1, 32'h0);
      clock_now += 32'd1;
    end
    send_item(1'b0, k, clock_now, 1'b1, 32'h0);
    send_item(1'b1, k, clock_now, 1'b0, 32'h0000_0003);
    clock_now += 700;
    send_item(1'b1, k, clock_now, 1'b1, 32'hffff_ffff);
  endtask

  task automatic test_modes();
    key_t k;
    k = rand_key();
    set_all(creg_pkg::MODE_OFF, 16'd0, 16'd0, 8'd255);
    send_item(1'b1, k, clock_now, 1'b1, 32'h5555_5555);
    send_item(1'b1, k, clock_now, 1'b0, 32'hc000_0000);
    send_item(1'b0, k, clock_now, 1'b0, 32'haaaa_aaaa);
    write_reg(creg_pkg::CFG_GUARD_MODE, {14'd0, creg_pkg::MODE_OPT_OUT});
    send_item(1'b1, k, clock_now, 1'b1, 32'h0000_0008);
    send_item(1'b1, k, clock_now + 5, 1'b0, 32'hffff_fff7 & 32'h5555_5555);
    write_reg(creg_pkg::CFG_GUARD_MODE, {14'd0, creg_pkg::MODE_ALWAYS});
    send_item(1'b0, k, clock_now + 5, 1'b0, 32'h0000_0008);
  endtask

  task automatic test_full_set();
    int unsigned s;
    s = $urandom_range(0, creg_pkg::SET_COUNT - 1);
    for (int i = 0; i <= creg_pkg::WAYS; i++)
      send_item(1'b1, key_in_set(s), clock_now, 1'b0, 32'h0);
  endtask

  task automatic test_limits();
    key_t k;
    k = rand_key();
    set_all(creg_pkg::MODE_ALWAYS, 16'hffff, 16'hffff, 8'd1);
    send_item(1'b1, k, 32'hffff_fff0, 1'b0, 32'h0);
    send_item(1'b1, k, 32'hffff_fff1, 1'b0, 32'h0);
    send_item(1'b0, k, 32'hffff_fffe, 1'b0, 32'h0);
    write_reg(creg_pkg::CFG_MAX_CRASHES, 16'd0);
    k = rand_key();
    send_item(1'b1, k, 32'h0, 1'b0, 32'h0);
    send_item(1'b1, k, 32'h0, 1'b0, 32'h0);
    send_item(1'b0, k, 32'h0, 1'b0, 32'h0);
    set_all(creg_pkg::MODE_ALWAYS, 16'd0, 16'd0, 8'd255);
    k = rand_key();
    send_item(1'b1, k, 32'd10, 1'b0, 32'h0);
    send_item(1'b1, k, 32'd11, 1'b0, 32'h0);
    send_item(1'b1, k, 32'd11, 1'b0, 32'h0);
  endtask

  task automatic test_random(input int n, input bit pause_mid);
    key_t k;
    logic [31:0] f;
    int r;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        drain();
        @(negedge clk);
      end
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) k = rand_key();
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      f = $urandom;
      if ($urandom_range(0, 9) < 7) f &= ~((f & creg_pkg::EVEN_BITS) << 1);
      r = $urandom_range(0, 99);
      if (r < 90) clock_now += $urandom_range(0, 15);
      else if (r < 97) clock_now += $urandom_range(0, 100000);
      else clock_now = $urandom;
      send_item($urandom_range(0, 99) < 55, k, clock_now, 1'($urandom_range(0, 1)), f);
    end
    quiet = 0;
  endtask

  initial begin
    for (int i = 0; i < creg_pkg::TABLE_ENTRIES; i++) tbl_valid[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < 16; i++) key_pool.push_back(rand_key());
    for (int i = 0; i < 6; i++) key_pool.push_back(key_in_set(set_of(key_pool[0])));

    test_reset_defaults();
    test_modes();
    test_full_set();
    test_limits();

    set_all(creg_pkg::MODE_ALWAYS, 16'd30, 16'd50, 8'd3);
    test_random(320, 1);
    set_all(creg_pkg::MODE_OPT_IN, 16'd20, 16'd40, 8'd2);
    test_random(320, 0);
    set_all(creg_pkg::MODE_OPT_OUT, 16'd60, 16'd0, 8'd4);
    test_random(320, 0);
    set_all(creg_pkg::MODE_ALWAYS, 16'd0, 16'd65535, 8'd1);
    test_random(300, 0);
    set_all(creg_pkg::MODE_OFF, 16'd65535, 16'd30, 8'd255);
    test_random(300, 0);
    set_all(creg_pkg::MODE_ALWAYS, 16'd15, 16'd25, 8'd0);
    test_random(340, 0);

    drain();
    if (errors == 0) $display("crash_rate_exec_guard test passed");
    else $display("crash_rate_exec_guard test failed");
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/creg_pkg.sv
design/crash_rate_exec_guard.sv
dv/crash_rate_exec_guard_tb.sv
